/* rtl/dpad_pkg.sv */
// Package of the dual pot average with deadband block.
// Holds the fixed field widths, the register map, reset values and shared types.
package dpad_pkg;

  localparam int unsigned SampleW = 12;
  localparam int unsigned LevelW  = 8;
  localparam int unsigned NumCh   = 2;
  localparam int unsigned PdataW  = 32;
  localparam int unsigned PaddrW  = 4;

  localparam logic [LevelW-1:0] DeadbandReset     = 8'd2;
  localparam logic              InvertFirstReset  = 1'b1;
  localparam logic              InvertSecondReset = 1'b0;

  typedef enum logic [1:0] {
    RegDeadband     = 2'd0,
    RegInvertFirst  = 2'd1,
    RegInvertSecond = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [LevelW-1:0] deadband;
    logic [NumCh-1:0]  invert;
  } cfg_t;

  typedef struct packed {
    logic valid;
    logic last;
  } stage_ctrl_t;

endpackage

/* rtl/dpad_sample_if.sv */
// Request channel carrying one pair of converter samples.
// Depends on dpad_pkg for the sample width.
interface dpad_sample_if;
  logic                         valid;
  logic                         ready;
  logic [dpad_pkg::SampleW-1:0] first_sample;
  logic [dpad_pkg::SampleW-1:0] second_sample;

  modport source (output valid, output first_sample, output second_sample, input ready);
  modport sink (input valid, input first_sample, input second_sample, output ready);
endinterface

/* rtl/dpad_level_if.sv */
// Result channel carrying both published levels and their change flags.
// Depends on dpad_pkg for the level width.
interface dpad_level_if;
  logic                        valid;
  logic                        ready;
  logic [dpad_pkg::LevelW-1:0] first_level;
  logic [dpad_pkg::LevelW-1:0] second_level;
  logic                        first_changed;
  logic                        second_changed;

  modport source (
    output valid, output first_level, output second_level,
    output first_changed, output second_changed, input ready
  );
  modport sink (
    input valid, input first_level, input second_level,
    input first_changed, input second_changed, output ready
  );
endinterface

/* rtl/dpad_regs.sv */
// APB-style configuration registers: deadband and the two invert bits.
// Depends on dpad_pkg for the register map, reset values and cfg_t.
module dpad_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dpad_pkg::PaddrW-1:0]  paddr,
  input  logic [dpad_pkg::PdataW-1:0]  pwdata,
  output logic [dpad_pkg::PdataW-1:0]  prdata,
  output logic                         pready,
  output dpad_pkg::cfg_t               cfg_o
);

  dpad_pkg::cfg_t     cfg_q;
  dpad_pkg::reg_idx_e idx;
  logic               wr_en;

  assign idx    = dpad_pkg::reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    unique case (idx)
      dpad_pkg::RegDeadband:     prdata = dpad_pkg::PdataW'(cfg_q.deadband);
      dpad_pkg::RegInvertFirst:  prdata = dpad_pkg::PdataW'(cfg_q.invert[0]);
      dpad_pkg::RegInvertSecond: prdata = dpad_pkg::PdataW'(cfg_q.invert[1]);
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.deadband  <= dpad_pkg::DeadbandReset;
      cfg_q.invert[0] <= dpad_pkg::InvertFirstReset;
      cfg_q.invert[1] <= dpad_pkg::InvertSecondReset;
    end else if (wr_en) begin
      unique case (idx)
        dpad_pkg::RegDeadband:     cfg_q.deadband  <= pwdata[dpad_pkg::LevelW-1:0];
        dpad_pkg::RegInvertFirst:  cfg_q.invert[0] <= pwdata[0];
        dpad_pkg::RegInvertSecond: cfg_q.invert[1] <= pwdata[0];
        default: ;
      endcase
    end
  end

endmodule

/* rtl/dpad_accum.sv */
// Accumulate stage: block sample counter and running sums of both channels.
// Depends on dpad_pkg for widths and stage_ctrl_t.
module dpad_accum #(
  parameter int unsigned BLOCK_SAMPLES = 16,
  parameter int unsigned ADC_BITS      = 12,
  localparam int unsigned MaskW = (ADC_BITS < dpad_pkg::SampleW) ? ADC_BITS
                                                                 : dpad_pkg::SampleW,
  localparam int unsigned IdxW  = $clog2(BLOCK_SAMPLES),
  localparam int unsigned SumW  = MaskW + IdxW
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     load_i,
  input  logic                                     valid_i,
  input  logic [dpad_pkg::SampleW-1:0]             first_sample_i,
  input  logic [dpad_pkg::SampleW-1:0]             second_sample_i,
  output dpad_pkg::stage_ctrl_t                    ctrl_o,
  output logic [dpad_pkg::NumCh-1:0][SumW-1:0]     sum_o
);

  logic [IdxW-1:0]                          idx_q;
  logic [dpad_pkg::NumCh-1:0][SumW-1:0]     run_q;
  logic [dpad_pkg::NumCh-1:0][SumW-1:0]     blk_q;
  logic [dpad_pkg::NumCh-1:0][SumW-1:0]     total;
  dpad_pkg::stage_ctrl_t                    ctrl_q;
  logic                                     last;
  logic                                     take;

  assign last  = (idx_q == IdxW'(BLOCK_SAMPLES - 1));
  assign take  = load_i & valid_i;
  assign total[0] = run_q[0] + SumW'(first_sample_i[MaskW-1:0]);
  assign total[1] = run_q[1] + SumW'(second_sample_i[MaskW-1:0]);

  assign ctrl_o = ctrl_q;
  assign sum_o  = blk_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
      idx_q  <= '0;
      run_q  <= '0;
    end else begin
      if (load_i) begin
        ctrl_q.valid <= valid_i;
        ctrl_q.last  <= valid_i & last;
      end
      if (take) begin
        if (last) begin
          idx_q <= '0;
          run_q <= '0;
        end else begin
          idx_q <= idx_q + 1'b1;
          run_q <= total;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      blk_q <= total;
    end
  end

endmodule

/* rtl/dpad_divide.sv */
// Divide stage: block sum to block average by reciprocal multiply, exact floor.
// Depends on dpad_pkg for widths and stage_ctrl_t.
module dpad_divide #(
  parameter int unsigned BLOCK_SAMPLES = 16,
  parameter int unsigned ADC_BITS      = 12,
  localparam int unsigned MaskW = (ADC_BITS < dpad_pkg::SampleW) ? ADC_BITS
                                                                 : dpad_pkg::SampleW,
  localparam int unsigned IdxW  = $clog2(BLOCK_SAMPLES),
  localparam int unsigned SumW  = MaskW + IdxW
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     load_i,
  input  dpad_pkg::stage_ctrl_t                    ctrl_i,
  input  logic [dpad_pkg::NumCh-1:0][SumW-1:0]     sum_i,
  output dpad_pkg::stage_ctrl_t                    ctrl_o,
  output logic [dpad_pkg::NumCh-1:0][MaskW-1:0]    avg_o
);

  localparam int unsigned Shift  = SumW + IdxW;
  localparam int unsigned RecipW = SumW + 1;
  localparam int unsigned ProdW  = SumW + RecipW;
  localparam longint unsigned RecipFull =
    ((64'd1 << Shift) + 64'(BLOCK_SAMPLES) - 64'd1) / 64'(BLOCK_SAMPLES);
  localparam logic [RecipW-1:0] Recip = RecipW'(RecipFull);

  logic [dpad_pkg::NumCh-1:0][ProdW-1:0]  prod;
  logic [dpad_pkg::NumCh-1:0][MaskW-1:0]  avg_q;
  dpad_pkg::stage_ctrl_t                  ctrl_q;

  always_comb begin
    for (int ch = 0; ch < dpad_pkg::NumCh; ch++) begin
      prod[ch] = ProdW'(sum_i[ch]) * ProdW'(Recip);
    end
  end

  assign ctrl_o = ctrl_q;
  assign avg_o  = avg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (load_i) begin
      ctrl_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && ctrl_i.last) begin
      for (int ch = 0; ch < dpad_pkg::NumCh; ch++) begin
        avg_q[ch] <= MaskW'(prod[ch] >> Shift);
      end
    end
  end

endmodule

/* rtl/dpad_level.sv */
// Level stage: scale to 8 bits, invert, hold filtered values, apply deadband.
// Depends on dpad_pkg for widths, cfg_t and stage_ctrl_t.
module dpad_level #(
  parameter int unsigned ADC_BITS = 12,
  localparam int unsigned MaskW = (ADC_BITS < dpad_pkg::SampleW) ? ADC_BITS
                                                                 : dpad_pkg::SampleW
) (
  input  logic                                               clk_i,
  input  logic                                               rst_ni,
  input  logic                                               load_i,
  input  dpad_pkg::stage_ctrl_t                              ctrl_i,
  input  logic [dpad_pkg::NumCh-1:0][MaskW-1:0]              avg_i,
  input  dpad_pkg::cfg_t                                     cfg_i,
  output logic                                               valid_o,
  output logic [dpad_pkg::NumCh-1:0][dpad_pkg::LevelW-1:0]   level_o,
  output logic [dpad_pkg::NumCh-1:0]                         changed_o
);

  localparam int unsigned LvW   = dpad_pkg::LevelW;
  localparam int unsigned ProdW = MaskW + LvW;

  logic [dpad_pkg::NumCh-1:0][ProdW-1:0] prod;
  logic [dpad_pkg::NumCh-1:0][LvW-1:0]   scaled;
  logic [dpad_pkg::NumCh-1:0][LvW-1:0]   filt_d;
  logic [dpad_pkg::NumCh-1:0][LvW-1:0]   filt_q;
  logic [dpad_pkg::NumCh-1:0][LvW-1:0]   diff;
  logic [dpad_pkg::NumCh-1:0][LvW-1:0]   pub_d;
  logic [dpad_pkg::NumCh-1:0][LvW-1:0]   pub_q;
  logic [dpad_pkg::NumCh-1:0]            chg_d;
  logic [dpad_pkg::NumCh-1:0]            chg_q;
  logic                                  valid_q;

  always_comb begin
    for (int ch = 0; ch < dpad_pkg::NumCh; ch++) begin
      prod[ch]   = {avg_i[ch], {LvW{1'b0}}} - ProdW'(avg_i[ch]);
      scaled[ch] = LvW'(prod[ch] >> ADC_BITS);
      if (cfg_i.invert[ch]) begin
        scaled[ch] = ~scaled[ch];
      end
      filt_d[ch] = ctrl_i.last ? scaled[ch] : filt_q[ch];
      diff[ch]   = (filt_d[ch] > pub_q[ch]) ? (filt_d[ch] - pub_q[ch])
                                            : (pub_q[ch] - filt_d[ch]);
      chg_d[ch]  = (diff[ch] > cfg_i.deadband);
      pub_d[ch]  = chg_d[ch] ? filt_d[ch] : pub_q[ch];
    end
  end

  assign valid_o   = valid_q;
  assign level_o   = pub_q;
  assign changed_o = chg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      filt_q  <= '0;
      pub_q   <= '0;
    end else if (load_i) begin
      valid_q <= ctrl_i.valid;
      if (ctrl_i.valid) begin
        filt_q <= filt_d;
        pub_q  <= pub_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && ctrl_i.valid) begin
      chg_q <= chg_d;
    end
  end

endmodule

/* rtl/dual_pot_average_deadband.sv */
// Dual pot average with deadband: top level, stage handshake and register port.
// Depends on dpad_pkg, dpad_sample_if, dpad_level_if, dpad_regs, dpad_accum,
// dpad_divide and dpad_level.
//
// Takes one pair of converter samples per request and returns one result per
// request: both published 8-bit levels and their change flags. Each channel
// averages blocks of BLOCK_SAMPLES samples (low ADC_BITS bits, at most 12),
// scales the average to avg*255/2^ADC_BITS, optionally inverts it, and moves
// the published level to it only when they differ by more than the deadband.
// The datapath has three register stages (accumulate, reciprocal divide,
// scale and deadband) and accepts a new request every cycle unless a stalled
// output has filled all three; the multiply in the divide stage sets the clock
// period. Each stage advances on its own when the next one is empty or moving,
// so bubbles close up while the output stalls. There is no clearing pass after
// reset. Registers: deadband at 0x0, invert_first at 0x4, invert_second at
// 0x8; write only while idle.
module dual_pot_average_deadband #(
  parameter int unsigned BLOCK_SAMPLES = 16,
  parameter int unsigned ADC_BITS      = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  dpad_sample_if.sink                   req_i,
  dpad_level_if.source                  rsp_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dpad_pkg::PaddrW-1:0]   paddr,
  input  logic [dpad_pkg::PdataW-1:0]   pwdata,
  output logic [dpad_pkg::PdataW-1:0]   prdata,
  output logic                          pready
);

  localparam int unsigned MaskW = (ADC_BITS < dpad_pkg::SampleW) ? ADC_BITS
                                                                 : dpad_pkg::SampleW;
  localparam int unsigned SumW  = MaskW + $clog2(BLOCK_SAMPLES);

  dpad_pkg::cfg_t                                           cfg;
  dpad_pkg::stage_ctrl_t                                    acc_ctrl;
  dpad_pkg::stage_ctrl_t                                    div_ctrl;
  logic [dpad_pkg::NumCh-1:0][SumW-1:0]                     acc_sum;
  logic [dpad_pkg::NumCh-1:0][MaskW-1:0]                    div_avg;
  logic [dpad_pkg::NumCh-1:0][dpad_pkg::LevelW-1:0]         level;
  logic [dpad_pkg::NumCh-1:0]                               changed;
  logic                                                     out_valid;
  logic                                                     acc_load;
  logic                                                     div_load;
  logic                                                     lvl_load;

  assign lvl_load    = ~out_valid | rsp_o.ready;
  assign div_load    = ~div_ctrl.valid | lvl_load;
  assign acc_load    = ~acc_ctrl.valid | div_load;
  assign req_i.ready = acc_load;

  assign rsp_o.valid          = out_valid;
  assign rsp_o.first_level    = level[0];
  assign rsp_o.second_level   = level[1];
  assign rsp_o.first_changed  = changed[0];
  assign rsp_o.second_changed = changed[1];

  dpad_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  dpad_accum #(
    .BLOCK_SAMPLES (BLOCK_SAMPLES),
    .ADC_BITS      (ADC_BITS)
  ) u_accum (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (acc_load),
    .valid_i         (req_i.valid),
    .first_sample_i  (req_i.first_sample),
    .second_sample_i (req_i.second_sample),
    .ctrl_o          (acc_ctrl),
    .sum_o           (acc_sum)
  );

  dpad_divide #(
    .BLOCK_SAMPLES (BLOCK_SAMPLES),
    .ADC_BITS      (ADC_BITS)
  ) u_divide (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (div_load),
    .ctrl_i (acc_ctrl),
    .sum_i  (acc_sum),
    .ctrl_o (div_ctrl),
    .avg_o  (div_avg)
  );

  dpad_level #(
    .ADC_BITS (ADC_BITS)
  ) u_level (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (lvl_load),
    .ctrl_i    (div_ctrl),
    .avg_i     (div_avg),
    .cfg_i     (cfg),
    .valid_o   (out_valid),
    .level_o   (level),
    .changed_o (changed)
  );

endmodule

/* sim/dual_pot_average_deadband_tb.sv */
// Testbench for dual_pot_average_deadband: random sample pairs with idle bursts and
// register writes between phases, checked against a scoreboard that predicts levels.
// Depends on dpad_pkg, dpad_sample_if, dpad_level_if and the block's RTL.
`timescale 1ns / 1ps

module dual_pot_average_deadband_tb;
  import dpad_pkg::*;

  localparam int BlockSamples = 16;
  localparam int AdcBits      = 12;
  localparam int PhaseCount   = 7;
  localparam int PhaseItems   = 132;
  localparam int LongHold     = 40;
  localparam int UnusedReg    = 3;

  typedef struct packed {
    logic [LevelW-1:0] first_level;
    logic [LevelW-1:0] second_level;
    logic              first_changed;
    logic              second_changed;
  } level_t;

  class level_scoreboard;
    logic [LevelW-1:0]  deadband;
    logic               invert_first;
    logic               invert_second;
    logic [3:0]         sample_index;
    logic [15:0]        first_sum;
    logic [15:0]        second_sum;
    logic [LevelW-1:0]  first_filtered;
    logic [LevelW-1:0]  second_filtered;
    logic [LevelW-1:0]  first_published;
    logic [LevelW-1:0]  second_published;
    level_t             pending_levels[$];
    int                 errors;
    int                 updates;

    function new();
      deadband         = DeadbandReset;
      invert_first     = InvertFirstReset;
      invert_second    = InvertSecondReset;
      sample_index     = '0;
      first_sum        = '0;
      second_sum       = '0;
      first_filtered   = '0;
      second_filtered  = '0;
      first_published  = '0;
      second_published = '0;
      errors           = 0;
      updates          = 0;
    endfunction

    function void write_reg(int idx, logic [PdataW-1:0] data);
      case (idx)
        int'(RegDeadband):     deadband      = data[LevelW-1:0];
        int'(RegInvertFirst):  invert_first  = data[0];
        int'(RegInvertSecond): invert_second = data[0];
        default: ;
      endcase
    endfunction

    function logic [LevelW-1:0] scale_block(logic [15:0] sum, logic invert);
      logic [19:0]       avg;
      logic [19:0]       prod;
      logic [LevelW-1:0] lvl;
      avg  = 20'(sum) / 20'(BlockSamples);
      prod = avg * 20'd255;
      lvl  = (prod >> AdcBits) > 20'd255 ? 8'd255 : LevelW'(prod >> AdcBits);
      return invert ? 8'd255 - lvl : lvl;
    endfunction

    function logic follow_level(logic [LevelW-1:0] filtered,
                                inout logic [LevelW-1:0] published);
      logic [LevelW-1:0] diff;
      diff = filtered > published ? filtered - published : published - filtered;
      if (diff > deadband) begin
        published = filtered;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void note_samples(logic [SampleW-1:0] first, logic [SampleW-1:0] second);
      level_t lv;
      first_sum  += 16'(first);
      second_sum += 16'(second);
      if (int'(sample_index) + 1 >= BlockSamples) begin
        first_filtered  = scale_block(first_sum, invert_first);
        second_filtered = scale_block(second_sum, invert_second);
        first_sum       = '0;
        second_sum      = '0;
        sample_index    = '0;
      end else begin
        sample_index++;
      end
      lv.first_changed  = follow_level(first_filtered, first_published);
      lv.second_changed = follow_level(second_filtered, second_published);
      lv.first_level    = first_published;
      lv.second_level   = second_published;
      pending_levels.push_back(lv);
    endfunction

    function void check_levels(level_t got);
      level_t want;
      if (pending_levels.size() == 0) begin
        $error("result with no pending request: levels %0d/%0d",
               got.first_level, got.second_level);
        errors++;
        return;
      end
      want = pending_levels.pop_front();
      if (got.first_level !== want.first_level) begin
        $error("first_level mismatch: expected %0d, got %0d", want.first_level, got.first_level);
        errors++;
      end
      if (got.second_level !== want.second_level) begin
        $error("second_level mismatch: expected %0d, got %0d",
               want.second_level, got.second_level);
        errors++;
      end
      if (got.first_changed !== want.first_changed) begin
        $error("first_changed mismatch: expected %0d, got %0d",
               want.first_changed, got.first_changed);
        errors++;
      end
      if (got.second_changed !== want.second_changed) begin
        $error("second_changed mismatch: expected %0d, got %0d",
               want.second_changed, got.second_changed);
        errors++;
      end
      updates += int'(want.first_changed) + int'(want.second_changed);
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PaddrW-1:0] paddr;
  logic [PdataW-1:0] pwdata;
  logic [PdataW-1:0] prdata;
  logic              pready;

  dpad_sample_if req_if ();
  dpad_level_if  rsp_if ();

  level_scoreboard sb = new();

  int accepted_pairs = 0;
  int reg_writes     = 0;
  int send_idle_pct  = 0;
  int rcv_idle_pct   = 20;
  bit hold_req       = 1'b0;

  dual_pot_average_deadband #(
    .BLOCK_SAMPLES(BlockSamples),
    .ADC_BITS     (AdcBits)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #500us;
    $display("Verification failed");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      sb.check_levels('{rsp_if.first_level, rsp_if.second_level,
                        rsp_if.first_changed, rsp_if.second_changed});
    end
  end

  initial begin : level_sink
    int burst;
    int held;
    burst = 0;
    held  = 0;
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        held     = LongHold;
      end
      if (held > 0) begin
        held--;
        rsp_if.ready <= 1'b0;
      end else if (burst > 0) begin
        burst--;
        rsp_if.ready <= 1'b0;
      end else if ($urandom_range(99) < rcv_idle_pct) begin
        burst = $urandom_range(0, 2);
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Write a register, then read it back unless the address is unmapped.
  task automatic program_reg(int idx, logic [PdataW-1:0] data);
    logic [PdataW-1:0] mask;
    mask = (idx == int'(RegDeadband)) ? PdataW'(8'hFF) : PdataW'(1);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= PaddrW'(idx * 4);
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    sb.write_reg(idx, data);
    reg_writes++;
    @(negedge clk_i);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    psel    <= (idx <= int'(RegInvertSecond));
    if (idx <= int'(RegInvertSecond)) begin
      @(negedge clk_i);
      penable <= 1'b1;
      @(posedge clk_i);
      while (!pready) @(posedge clk_i);
      if ((prdata & mask) !== (data & mask)) begin
        $error("register %0d readback mismatch: expected %0h, got %0h",
               idx, data & mask, prdata & mask);
        sb.errors++;
      end
      @(negedge clk_i);
      psel    <= 1'b0;
      penable <= 1'b0;
    end
  endtask

  // Offer one sample pair and hold it until accepted; returns at a falling edge.
  task automatic send_pair(logic [SampleW-1:0] first, logic [SampleW-1:0] second);
    req_if.valid         <= 1'b1;
    req_if.first_sample  <= first;
    req_if.second_sample <= second;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    sb.note_samples(first, second);
    accepted_pairs++;
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    req_if.valid <= 1'b0;
    while (sb.pending_levels.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  function automatic logic [SampleW-1:0] jitter(int base, int spread);
    int v;
    v = base + int'($urandom_range(0, 2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return SampleW'(v);
  endfunction

  initial begin : stimulus
    int          base[2];
    int          spread[2];
    int          db;
    logic        inv1;
    logic        inv2;
    logic [SampleW-1:0] smp[2];
    rst_ni               = 1'b0;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    req_if.valid         = 1'b0;
    req_if.first_sample  = '0;
    req_if.second_sample = '0;
    base   = '{0, 0};
    spread = '{0, 0};
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // full-scale block on one channel, zero on the other, then extremes mixed
    for (int i = 0; i < BlockSamples; i++) send_pair(12'hFFF, 12'h000);
    send_pair(12'h000, 12'hFFF);
    send_pair(12'hFFF, 12'hFFF);
    send_pair(12'h000, 12'h000);
    send_pair(12'h800, 12'h7FF);
    send_pair(12'h555, 12'hAAA);
    send_pair(12'hAAA, 12'h555);
    send_pair(12'h001, 12'hFFE);
    send_pair(12'hFFE, 12'h001);
    drain_results();

    for (int phase = 0; phase < PhaseCount; phase++) begin
      case (phase)
        0: begin db = 0;   inv1 = 1'b0; inv2 = 1'b0; send_idle_pct = 20; rcv_idle_pct = 20; end
        1: begin db = 255; inv1 = 1'b1; inv2 = 1'b1; send_idle_pct = 0;  rcv_idle_pct = 0;  end
        2: begin db = 1;   inv1 = 1'b0; inv2 = 1'b1; send_idle_pct = 15; rcv_idle_pct = 15; end
        3: begin
          db = $urandom_range(0, 255); inv1 = $urandom_range(0, 1); inv2 = $urandom_range(0, 1);
          send_idle_pct = 30; rcv_idle_pct = 30;
        end
        4: begin
          db = $urandom_range(0, 12); inv1 = $urandom_range(0, 1); inv2 = $urandom_range(0, 1);
          send_idle_pct = 10; rcv_idle_pct = 40;
        end
        5: begin
          db = $urandom_range(3, 40); inv1 = $urandom_range(0, 1); inv2 = $urandom_range(0, 1);
          send_idle_pct = 40; rcv_idle_pct = 10;
        end
        default: begin
          db = DeadbandReset; inv1 = InvertFirstReset; inv2 = InvertSecondReset;
          send_idle_pct = 0; rcv_idle_pct = 0;
        end
      endcase
      program_reg(int'(RegDeadband), ($urandom() & ~32'hFF) | PdataW'(db));
      program_reg(int'(RegInvertFirst), ($urandom() & ~32'h1) | PdataW'(inv1));
      program_reg(int'(RegInvertSecond), ($urandom() & ~32'h1) | PdataW'(inv2));
      if (phase == 3) program_reg(UnusedReg, $urandom());
      if (phase == 2 || phase == 4) hold_req = 1'b1;

      for (int n = 0; n < PhaseItems; n++) begin
        if (accepted_pairs % BlockSamples == 0) begin
          for (int c = 0; c < 2; c++) begin
            case ($urandom_range(0, 7))
              0: begin base[c] = 2048; spread[c] = 2048; end
              1: begin base[c] = $urandom_range(0, 1) * 4095; spread[c] = 0; end
              default: begin
                base[c]   = $urandom_range(0, 4095);
                spread[c] = 4 << (3 * $urandom_range(0, 2));
                if ($urandom_range(0, 3) == 0) spread[c] = 0;
              end
            endcase
          end
        end
        for (int c = 0; c < 2; c++) smp[c] = jitter(base[c], spread[c]);
        if ($urandom_range(99) < send_idle_pct) begin
          req_if.valid <= 1'b0;
          repeat ($urandom_range(1, 3)) @(negedge clk_i);
        end
        send_pair(smp[0], smp[1]);
      end
      drain_results();
    end

    repeat (10) @(negedge clk_i);
    $display("Sent %0d sample pairs over %0d register writes across %0d settings.",
             accepted_pairs, reg_writes, PhaseCount + 1);
    $display("Checked %0d published level updates.", sb.updates);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* dual_pot_average_deadband.f */
rtl/dpad_pkg.sv
rtl/dpad_sample_if.sv
rtl/dpad_level_if.sv
rtl/dpad_regs.sv
rtl/dpad_accum.sv
rtl/dpad_divide.sv
rtl/dpad_level.sv
rtl/dual_pot_average_deadband.sv
sim/dual_pot_average_deadband_tb.sv
